/* src/psp_pkg.sv */
package psp_pkg;

    localparam int SLOT_W = 5;
    localparam int CNT_W = 6;
    localparam int OP_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 6'd7;

    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
    localparam logic [OP_W-1:0] OP_MARK_TX = 3'd2;
    localparam logic [OP_W-1:0] OP_MARK_RX = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND_TX = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND_RX = 3'd5;
    localparam logic [OP_W-1:0] OP_RESTART = 3'd6;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_TX_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_LIMIT = 1'd1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic              from_start;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot_out;
        logic              slot_is_tx;
        logic              slot_is_rx;
        logic [CNT_W-1:0]  busy_count;
        logic [CNT_W-1:0]  free_count;
        logic [CNT_W-1:0]  tx_room;
        logic [CNT_W-1:0]  rx_room;
        logic [CNT_W-1:0]  tx_taken_count;
        logic [CNT_W-1:0]  rx_taken_count;
    } rsp_t;

endpackage

/* src/psp_lowest.sv */
module psp_lowest
    import psp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0]  vec,
    output logic              hit,
    output logic [SLOT_W-1:0] index
);

    logic [WIDTH-1:0] onehot;

    // Isolate the lowest set bit, then encode it.
    assign onehot = vec & (~vec + WIDTH'(1));
    assign hit    = |vec;

    always_comb begin
        index = '0;
        for (int i = 0; i < WIDTH; i++) begin
            if (onehot[i]) begin
                index = SLOT_W'(i);
            end
        end
    end

endmodule

/* src/psp_core.sv */
module psp_core
    import psp_pkg::*;
#(
    parameter int POOL_SLOTS = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  req_t             req,
    input  logic [CNT_W-1:0] tx_limit,
    input  logic [CNT_W-1:0] rx_limit,
    output rsp_t             rsp
);

    localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_SLOTS);

    logic [POOL_SLOTS-1:0] taken_reg, taken_next;
    logic [POOL_SLOTS-1:0] tx_reg, tx_next;
    logic [POOL_SLOTS-1:0] rx_reg, rx_next;
    logic [CNT_W-1:0]      busy_reg, busy_next;
    logic [CNT_W-1:0]      tx_cnt_reg, tx_cnt_next;
    logic [CNT_W-1:0]      rx_cnt_reg, rx_cnt_next;
    logic [CNT_W-1:0]      tx_taken_reg, tx_taken_next;
    logic [CNT_W-1:0]      rx_taken_reg, rx_taken_next;

    logic [POOL_SLOTS-1:0] slot_hot;
    logic                  slot_ok;
    logic [POOL_SLOTS-1:0] start_mask;
    logic [POOL_SLOTS-1:0] find_cand;
    logic                  free_hit, find_hit;
    logic [SLOT_W-1:0]     free_idx, find_idx;
    logic [POOL_SLOTS-1:0] free_hot;

    always_comb begin
        for (int i = 0; i < POOL_SLOTS; i++) begin
            slot_hot[i]   = (req.slot == SLOT_W'(i));
            start_mask[i] = req.from_start || ((SLOT_W + 1)'(i) > {1'b0, req.slot});
        end
    end

    assign slot_ok   = |slot_hot;
    assign find_cand = taken_reg & ((req.op == OP_FIND_TX) ? tx_reg : rx_reg) & start_mask;

    // The lowest clear bit of the taken vector is the slot that an allocation claims.
    assign free_hot = ~taken_reg & (taken_reg + POOL_SLOTS'(1));

    psp_lowest #(.WIDTH(POOL_SLOTS)) u_free_enc (
        .vec    (~taken_reg),
        .hit    (free_hit),
        .index  (free_idx)
    );

    psp_lowest #(.WIDTH(POOL_SLOTS)) u_find_enc (
        .vec    (find_cand),
        .hit    (find_hit),
        .index  (find_idx)
    );

    always_comb begin
        taken_next    = taken_reg;
        tx_next       = tx_reg;
        rx_next       = rx_reg;
        busy_next     = busy_reg;
        tx_cnt_next   = tx_cnt_reg;
        rx_cnt_next   = rx_cnt_reg;
        tx_taken_next = tx_taken_reg;
        rx_taken_next = rx_taken_reg;
        rsp.found     = 1'b0;
        rsp.slot_out  = '0;
        unique case (req.op)
            OP_ALLOC: begin
                // The chosen slot was free, so the taken counts do not move.
                if (free_hit) begin
                    taken_next   = taken_reg | free_hot;
                    tx_next      = tx_reg & ~free_hot;
                    rx_next      = rx_reg & ~free_hot;
                    busy_next    = (busy_reg >= POOL_CNT) ? POOL_CNT : busy_reg + 1'b1;
                    rsp.found    = 1'b1;
                    rsp.slot_out = free_idx;
                end
            end
            OP_FREE: begin
                if (slot_ok) begin
                    if (|(tx_reg & slot_hot)) begin
                        tx_cnt_next = (tx_cnt_reg == '0) ? '0 : tx_cnt_reg - 1'b1;
                    end else if (|(rx_reg & slot_hot)) begin
                        rx_cnt_next = (rx_cnt_reg == '0) ? '0 : rx_cnt_reg - 1'b1;
                    end
                    if (|(taken_reg & tx_reg & slot_hot)) begin
                        tx_taken_next = tx_taken_reg - 1'b1;
                    end
                    if (|(taken_reg & rx_reg & slot_hot)) begin
                        rx_taken_next = rx_taken_reg - 1'b1;
                    end
                    taken_next = taken_reg & ~slot_hot;
                    tx_next    = tx_reg & ~slot_hot;
                    rx_next    = rx_reg & ~slot_hot;
                    busy_next  = (busy_reg == '0) ? '0 : busy_reg - 1'b1;
                end
            end
            OP_MARK_TX: begin
                if (slot_ok) begin
                    tx_cnt_next = (tx_cnt_reg >= POOL_CNT) ? POOL_CNT : tx_cnt_reg + 1'b1;
                    tx_next     = tx_reg | slot_hot;
                    if (|(taken_reg & ~tx_reg & slot_hot)) begin
                        tx_taken_next = tx_taken_reg + 1'b1;
                    end
                end
            end
            OP_MARK_RX: begin
                if (slot_ok) begin
                    rx_cnt_next = (rx_cnt_reg >= POOL_CNT) ? POOL_CNT : rx_cnt_reg + 1'b1;
                    rx_next     = rx_reg | slot_hot;
                    if (|(taken_reg & ~rx_reg & slot_hot)) begin
                        rx_taken_next = rx_taken_reg + 1'b1;
                    end
                end
            end
            OP_FIND_TX, OP_FIND_RX: begin
                rsp.found    = find_hit;
                rsp.slot_out = find_hit ? find_idx : '0;
            end
            OP_RESTART: begin
                taken_next    = '0;
                tx_next       = '0;
                rx_next       = '0;
                busy_next     = '0;
                tx_cnt_next   = '0;
                rx_cnt_next   = '0;
                tx_taken_next = '0;
                rx_taken_next = '0;
            end
            OP_QUERY: begin
            end
            default: begin
            end
        endcase
        rsp.slot_is_tx     = |(tx_next & slot_hot);
        rsp.slot_is_rx     = |(rx_next & slot_hot);
        rsp.busy_count     = busy_next;
        rsp.free_count     = POOL_CNT - busy_next;
        rsp.tx_room        = (tx_limit > tx_cnt_next) ? tx_limit - tx_cnt_next : '0;
        rsp.rx_room        = (rx_limit > rx_cnt_next) ? rx_limit - rx_cnt_next : '0;
        rsp.tx_taken_count = tx_taken_next;
        rsp.rx_taken_count = rx_taken_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taken_reg    <= '0;
            tx_reg       <= '0;
            rx_reg       <= '0;
            busy_reg     <= '0;
            tx_cnt_reg   <= '0;
            rx_cnt_reg   <= '0;
            tx_taken_reg <= '0;
            rx_taken_reg <= '0;
        end else if (step) begin
            taken_reg    <= taken_next;
            tx_reg       <= tx_next;
            rx_reg       <= rx_next;
            busy_reg     <= busy_next;
            tx_cnt_reg   <= tx_cnt_next;
            rx_cnt_reg   <= rx_cnt_next;
            tx_taken_reg <= tx_taken_next;
            rx_taken_reg <= rx_taken_next;
        end
    end

endmodule

/* src/packet_slot_pool_allocator_top.sv */
// Channel    Ports                            Direction
// request    s_valid / s_ready / s_data       in
// result     m_valid / m_ready / m_data       out
// config     cfg_wr_en / cfg_index / cfg_wdata in, write only
//
// One request is accepted per cycle unless the result stalls; its result is registered:
// the request register feeds the slot logic, and the result register loads its output.
// The flag vectors are updated in the same cycle that the result register loads.
// A stalled result holds the request register; a new request enters as soon as it moves.
// Reset clears every flag and counter and sets both limits to seven.
module packet_slot_pool_allocator_top
    import psp_pkg::*;
#(
    parameter int POOL_SLOTS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  req_t                 s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rsp_t                 m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_wdata
);

    logic             in_valid_reg;
    req_t             in_data_reg;
    logic             m_valid_reg;
    rsp_t             m_data_reg;
    logic [CNT_W-1:0] tx_limit_reg;
    logic [CNT_W-1:0] rx_limit_reg;
    logic             step;
    rsp_t             core_rsp;

    assign step    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_limit_reg <= LIMIT_RESET;
            rx_limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TX_LIMIT: tx_limit_reg <= cfg_wdata;
                CFG_RX_LIMIT: rx_limit_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    psp_core #(.POOL_SLOTS(POOL_SLOTS)) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .req      (in_data_reg),
        .tx_limit (tx_limit_reg),
        .rx_limit (rx_limit_reg),
        .rsp      (core_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_data_reg <= core_rsp;
        end
    end

    // A blocked request side means a request waits behind a stalled result.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg && !m_ready))
        else $error("request side blocked without a stalled result");

    a_step_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid)
        else $error("processed request produced no result");

    a_pool_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.busy_count + m_data.free_count) == CNT_W'(POOL_SLOTS)))
        else $error("busy and free counts do not cover the pool");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
    import psp_pkg::*;

    localparam int POOL = 32;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 275;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int SETTLE_CYCLES = 4;
    localparam int TIMEOUT_NS = 2_000_000;

    typedef enum int {FL_FILL, FL_MARK, FL_FIND, FL_DRAIN, FL_NOISE} flavor_e;

    // Predicts the pool state and the result of every accepted request.
    class pool_tracker;
        logic [POOL-1:0]  taken;
        logic [POOL-1:0]  tx_mark;
        logic [POOL-1:0]  rx_mark;
        int               busy;
        int               tx_cnt;
        int               rx_cnt;
        logic [CNT_W-1:0] tx_limit;
        logic [CNT_W-1:0] rx_limit;
        rsp_t             expected_rsps[$];
        int               mismatches;
        int               checked;
        int               op_count[8];
        int               full_allocs;
        int               find_hits;

        function new();
            clear_pool();
            tx_limit = LIMIT_RESET;
            rx_limit = LIMIT_RESET;
            mismatches = 0;
            checked = 0;
            full_allocs = 0;
            find_hits = 0;
            foreach (op_count[i]) op_count[i] = 0;
        endfunction

        function void clear_pool();
            taken = '0;
            tx_mark = '0;
            rx_mark = '0;
            busy = 0;
            tx_cnt = 0;
            rx_cnt = 0;
        endfunction

        function void set_limits(logic [CNT_W-1:0] tx_val, logic [CNT_W-1:0] rx_val);
            tx_limit = tx_val;
            rx_limit = rx_val;
        endfunction

        function int inc_sat(int c);
            return (c >= POOL) ? POOL : c + 1;
        endfunction

        function int dec_sat(int c);
            return (c == 0) ? 0 : c - 1;
        endfunction

        function int room_left(logic [CNT_W-1:0] limit, int cnt);
            return (int'(limit) > cnt) ? int'(limit) - cnt : 0;
        endfunction

        function int lowest_set(logic [POOL-1:0] cand, int start);
            for (int i = start; i < POOL; i++) begin
                if (cand[i]) return i;
            end
            return -1;
        endfunction

        function void note_request(req_t r);
            rsp_t e;
            int   hit;
            bit   in_pool;
            hit = -1;
            in_pool = int'(r.slot) < POOL;
            op_count[r.op]++;
            case (r.op)
                OP_ALLOC: begin
                    hit = lowest_set(~taken, 0);
                    if (hit >= 0) begin
                        taken[hit] = 1'b1;
                        tx_mark[hit] = 1'b0;
                        rx_mark[hit] = 1'b0;
                        busy = inc_sat(busy);
                    end else begin
                        full_allocs++;
                    end
                end
                OP_FREE: begin
                    if (in_pool) begin
                        // A slot carrying both marks only gives back its transmit count.
                        if (tx_mark[r.slot]) tx_cnt = dec_sat(tx_cnt);
                        else if (rx_mark[r.slot]) rx_cnt = dec_sat(rx_cnt);
                        taken[r.slot] = 1'b0;
                        tx_mark[r.slot] = 1'b0;
                        rx_mark[r.slot] = 1'b0;
                        busy = dec_sat(busy);
                    end
                end
                OP_MARK_TX: begin
                    if (in_pool) begin
                        tx_cnt = inc_sat(tx_cnt);
                        tx_mark[r.slot] = 1'b1;
                    end
                end
                OP_MARK_RX: begin
                    if (in_pool) begin
                        rx_cnt = inc_sat(rx_cnt);
                        rx_mark[r.slot] = 1'b1;
                    end
                end
                OP_FIND_TX, OP_FIND_RX: begin
                    hit = lowest_set(taken & ((r.op == OP_FIND_TX) ? tx_mark : rx_mark),
                                     r.from_start ? 0 : int'(r.slot) + 1);
                    if (hit >= 0) find_hits++;
                end
                OP_RESTART: clear_pool();
                default: ;
            endcase
            e.found = (hit >= 0);
            e.slot_out = (hit >= 0) ? SLOT_W'(hit) : '0;
            e.slot_is_tx = in_pool ? tx_mark[r.slot] : 1'b0;
            e.slot_is_rx = in_pool ? rx_mark[r.slot] : 1'b0;
            e.busy_count = CNT_W'(busy);
            e.free_count = CNT_W'((busy < POOL) ? POOL - busy : 0);
            e.tx_room = CNT_W'(room_left(tx_limit, tx_cnt));
            e.rx_room = CNT_W'(room_left(rx_limit, rx_cnt));
            e.tx_taken_count = CNT_W'($countones(taken & tx_mark));
            e.rx_taken_count = CNT_W'($countones(taken & rx_mark));
            expected_rsps.push_back(e);
        endfunction

        function void compare(string field, logic [CNT_W-1:0] want, logic [CNT_W-1:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0d, got %0d", field, want, seen);
                mismatches++;
            end
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;
            if (expected_rsps.size() == 0) begin
                $error("result arrived with no request outstanding");
                mismatches++;
                return;
            end
            e = expected_rsps.pop_front();
            checked++;
            compare("found", e.found, got.found);
            compare("slot_out", e.slot_out, got.slot_out);
            compare("slot_is_tx", e.slot_is_tx, got.slot_is_tx);
            compare("slot_is_rx", e.slot_is_rx, got.slot_is_rx);
            compare("busy_count", e.busy_count, got.busy_count);
            compare("free_count", e.free_count, got.free_count);
            compare("tx_room", e.tx_room, got.tx_room);
            compare("rx_room", e.rx_room, got.rx_room);
            compare("tx_taken_count", e.tx_taken_count, got.tx_taken_count);
            compare("rx_taken_count", e.rx_taken_count, got.rx_taken_count);
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    req_t                 s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    rsp_t                 m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_wdata = '0;

    bit                   hold_results = 1'b0;
    pool_tracker          tracker;

    packet_slot_pool_allocator_top #(
        .POOL_SLOTS(POOL)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) tracker.note_request(s_data);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_result(m_data);
    end

    // Result side: stretches of always-ready, random stalls or alternating cycles,
    // plus one long hold-off when the stimulus asks for it.
    initial begin : result_sink
        int stretch;
        int mode;
        forever begin
            stretch = $urandom_range(80, 10);
            mode = $urandom_range(2);
            repeat (stretch) begin
                if (hold_results) begin
                    m_ready <= 1'b0;
                    repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                    hold_results = 1'b0;
                end
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(99) >= 35);
                    default: m_ready <= ~m_ready;
                endcase
                @(posedge aclk);
            end
        end
    end

    function automatic req_t req_of(logic [OP_W-1:0] op, int slot, bit from_start);
        req_t r;
        r.op = op;
        r.slot = SLOT_W'(slot);
        r.from_start = from_start;
        return r;
    endfunction

    // Mostly aims at slots that are allocated so that marks, finds and frees hit.
    function automatic int pick_slot();
        int start;
        if (tracker.taken != '0 && $urandom_range(99) < 65) begin
            start = $urandom_range(POOL - 1);
            for (int i = 0; i < POOL; i++) begin
                if (tracker.taken[(start + i) % POOL]) return (start + i) % POOL;
            end
        end
        return $urandom_range(POOL - 1);
    endfunction

    function automatic req_t make_req(flavor_e fl);
        logic [OP_W-1:0] op;
        op = OP_W'($urandom_range(7));
        if (op == OP_RESTART && $urandom_range(7) != 0) op = OP_QUERY;
        if (fl != FL_NOISE && $urandom_range(99) < 65) begin
            case (fl)
                FL_FILL: op = OP_ALLOC;
                FL_MARK: op = $urandom_range(1) ? OP_MARK_TX : OP_MARK_RX;
                FL_FIND: op = $urandom_range(1) ? OP_FIND_TX : OP_FIND_RX;
                default: op = OP_FREE;
            endcase
        end
        return req_of(op, pick_slot(), $urandom_range(3) == 0);
    endfunction

    task automatic send_request(input req_t r);
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Dropping s_valid and waiting before the read lets the last accepted request be noted.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.expected_rsps.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limits(input logic [CNT_W-1:0] tx_val, input logic [CNT_W-1:0] rx_val);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TX_LIMIT;
        cfg_wdata <= tx_val;
        @(posedge aclk);
        cfg_index <= CFG_RX_LIMIT;
        cfg_wdata <= rx_val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_limits(tx_val, rx_val);
    endtask

    task automatic run_random(input int n, input bit with_hold);
        int      done;
        int      len;
        int      burst_left;
        flavor_e fl;
        done = 0;
        burst_left = $urandom_range(24, 1);
        while (done < n) begin
            fl = flavor_e'($urandom_range(4));
            len = $urandom_range(40, 4);
            for (int k = 0; k < len && done < n; k++) begin
                send_request(make_req(fl));
                done++;
                // Results back up while requests keep coming, so the input stalls.
                if (with_hold && done == n / 2) hold_results = 1'b1;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(24, 1);
                    if ($urandom_range(3) != 0) begin
                        s_valid <= 1'b0;
                        repeat ($urandom_range(8, 1)) @(posedge aclk);
                    end
                end
            end
        end
        drain();
    endtask

    initial begin : stimulus
        logic [CNT_W-1:0] tx_set[PHASES];
        logic [CNT_W-1:0] rx_set[PHASES];
        req_t             directed[$];
        tx_set = '{7, 0, 32, 31, 1, 20};
        rx_set = '{7, 32, 0, 1, 31, 7};
        tx_set[4] = CNT_W'($urandom_range(32));
        rx_set[5] = CNT_W'($urandom_range(32));
        tracker = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Empty pool, two allocations, marks on taken and untaken slots, finds that start
        // from zero, after a slot and at the last slot; frees, restart, then free, alloc, query.
        directed.push_back(req_of(OP_QUERY, 0, 1'b0));
        directed.push_back(req_of(OP_FIND_TX, 0, 1'b1));
        directed.push_back(req_of(OP_ALLOC, 31, 1'b0));
        directed.push_back(req_of(OP_ALLOC, 0, 1'b0));
        directed.push_back(req_of(OP_MARK_TX, 0, 1'b0));
        directed.push_back(req_of(OP_MARK_RX, 1, 1'b0));
        directed.push_back(req_of(OP_MARK_TX, 31, 1'b0));
        directed.push_back(req_of(OP_FIND_TX, 0, 1'b1));
        directed.push_back(req_of(OP_FIND_TX, 0, 1'b0));
        directed.push_back(req_of(OP_FIND_RX, 31, 1'b0));
        directed.push_back(req_of(OP_FIND_RX, 0, 1'b0));
        directed.push_back(req_of(OP_QUERY, 31, 1'b1));
        directed.push_back(req_of(OP_FREE, 0, 1'b0));
        directed.push_back(req_of(OP_FREE, 1, 1'b0));
        directed.push_back(req_of(OP_FREE, 5, 1'b0));
        directed.push_back(req_of(OP_RESTART, 31, 1'b1));
        directed.push_back(req_of(OP_FREE, 3, 1'b0));
        directed.push_back(req_of(OP_ALLOC, 0, 1'b1));
        directed.push_back(req_of(OP_QUERY, 0, 1'b0));
        foreach (directed[i]) send_request(directed[i]);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) write_limits(tx_set[ph], rx_set[ph]);
            run_random(ITEMS_PER_PHASE, ph == 2);
        end

        foreach (tracker.expected_rsps[i]) $error("result for a request never arrived");
        $display("Checked %0d results over %0d limit settings: %0d alloc, %0d free, %0d mark,",
                 tracker.checked, PHASES, tracker.op_count[OP_ALLOC], tracker.op_count[OP_FREE],
                 tracker.op_count[OP_MARK_TX] + tracker.op_count[OP_MARK_RX]);
        $display("%0d find (%0d hits), %0d restart; %0d allocs met a full pool.",
                 tracker.op_count[OP_FIND_TX] + tracker.op_count[OP_FIND_RX],
                 tracker.find_hits, tracker.op_count[OP_RESTART], tracker.full_allocs);
        if (tracker.mismatches == 0 && tracker.expected_rsps.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/psp_pkg.sv
src/psp_lowest.sv
src/psp_core.sv
src/packet_slot_pool_allocator_top.sv
tb/tb.sv
